// File: rtl/cro_pkg.sv
// ============================================================================
// cro_pkg
// Shared types, widths and helpers for the circle ring overlay pipeline.
// ============================================================================
`default_nettype none

package cro_pkg;

  localparam int COORD_BITS  = 12;
  localparam int RADIUS_BITS = 10;

  localparam int THICK_W   = 9;
  localparam int COLOR_W   = 32;
  localparam int PIX_W     = 32;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  localparam int CTR_W  = COORD_BITS + 2;
  localparam int DIM_W  = COORD_BITS + 1;
  localparam int DX_W   = COORD_BITS + 3;
  localparam int ABS_W  = COORD_BITS + 2;
  localparam int SQ_W   = 2 * ABS_W;
  localparam int D_W    = SQ_W + 1;
  localparam int D4_W   = D_W + 2;
  localparam int HI_W   = ((RADIUS_BITS + 1 > THICK_W) ? RADIUS_BITS + 1 : THICK_W) + 2;
  localparam int HSQ_W  = 2 * (HI_W - 1);
  localparam int RSQ_W  = 2 * RADIUS_BITS;
  localparam int CMP_W  = (D4_W > HSQ_W) ? D4_W : HSQ_W;
  localparam int BOX_W  = (ABS_W > RADIUS_BITS) ? ABS_W : RADIUS_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X       = 3'd0,
    REG_CENTER_Y       = 3'd1,
    REG_CIRCLE_RADIUS  = 3'd2,
    REG_RING_THICKNESS = 3'd3,
    REG_DRAW_COLOR     = 3'd4,
    REG_CHANNEL_MODE   = 3'd5,
    REG_IMAGE_WIDTH    = 3'd6,
    REG_IMAGE_HEIGHT   = 3'd7
  } cfg_reg_t;

  localparam logic [MODE_W-1:0] MODE_ONE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_THREE = 2'd1;

  localparam logic signed [THICK_W-1:0] THICK_FILLED = -9'sd1;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [PIX_W-1:0]      pixel_in;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             painted;
  } out_t;

  typedef struct packed {
    logic signed [CTR_W-1:0] center_x;
    logic signed [CTR_W-1:0] center_y;
    logic [RADIUS_BITS-1:0]  radius;
    logic [COLOR_W-1:0]      color;
    logic [MODE_W-1:0]       mode;
    logic [DIM_W-1:0]        width;
    logic [DIM_W-1:0]        height;
    logic                    filled;
    logic                    hi_pos;
    logic                    lo_pos;
    logic [HSQ_W-1:0]        hi_sq;
    logic [HSQ_W-1:0]        lo_sq;
    logic [RSQ_W-1:0]        r_sq;
  } cfg_t;

  function automatic logic [PIX_W-1:0] chan_mask(input logic [MODE_W-1:0] mode);
    logic [PIX_W-1:0] m;
    m = '1;
    if (mode == MODE_ONE) begin
      m = 32'h0000_00FF;
    end else if (mode == MODE_THREE) begin
      m = 32'h00FF_FFFF;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// File: rtl/cro_cfg.sv
// ============================================================================
// cro_cfg
// Configuration registers and the shape constants derived from them.
// ============================================================================
`default_nettype none

module cro_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [cro_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [cro_pkg::CFG_DAT_W-1:0]   cfg_wdata,
  output cro_pkg::cfg_t                        cfg
);

  logic signed [cro_pkg::CTR_W-1:0]   center_x_r;
  logic signed [cro_pkg::CTR_W-1:0]   center_y_r;
  logic [cro_pkg::RADIUS_BITS-1:0]    radius_r;
  logic signed [cro_pkg::THICK_W-1:0] thick_r;
  logic [cro_pkg::COLOR_W-1:0]        color_r;
  logic [cro_pkg::MODE_W-1:0]         mode_r;
  logic [cro_pkg::DIM_W-1:0]          width_r;
  logic [cro_pkg::DIM_W-1:0]          height_r;

  logic signed [cro_pkg::HI_W-1:0]    two_r;
  logic signed [cro_pkg::HI_W-1:0]    thick_ext;
  logic signed [cro_pkg::HI_W-1:0]    hi_nxt;
  logic signed [cro_pkg::HI_W-1:0]    lo_nxt;
  logic signed [cro_pkg::HI_W-1:0]    hi_r;
  logic signed [cro_pkg::HI_W-1:0]    lo_r;
  logic                               filled_r;
  logic [cro_pkg::HI_W-2:0]           hi_mag;
  logic [cro_pkg::HI_W-2:0]           lo_mag;
  logic [cro_pkg::HSQ_W-1:0]          hi_sq_r;
  logic [cro_pkg::HSQ_W-1:0]          lo_sq_r;
  logic [cro_pkg::RSQ_W-1:0]          r_sq_r;
  logic                               hi_pos_r;
  logic                               lo_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      radius_r   <= '0;
      thick_r    <= cro_pkg::THICK_W'(1);
      color_r    <= '0;
      mode_r     <= cro_pkg::MODE_ONE;
      width_r    <= cro_pkg::DIM_W'(1) << cro_pkg::COORD_BITS;
      height_r   <= cro_pkg::DIM_W'(1) << cro_pkg::COORD_BITS;
    end else if (cfg_we) begin
      unique case (cro_pkg::cfg_reg_t'(cfg_index))
        cro_pkg::REG_CENTER_X:       center_x_r <= $signed(cfg_wdata[cro_pkg::CTR_W-1:0]);
        cro_pkg::REG_CENTER_Y:       center_y_r <= $signed(cfg_wdata[cro_pkg::CTR_W-1:0]);
        cro_pkg::REG_CIRCLE_RADIUS:  radius_r   <= cfg_wdata[cro_pkg::RADIUS_BITS-1:0];
        cro_pkg::REG_RING_THICKNESS: thick_r    <= $signed(cfg_wdata[cro_pkg::THICK_W-1:0]);
        cro_pkg::REG_DRAW_COLOR:     color_r    <= cfg_wdata[cro_pkg::COLOR_W-1:0];
        cro_pkg::REG_CHANNEL_MODE:   mode_r     <= cfg_wdata[cro_pkg::MODE_W-1:0];
        cro_pkg::REG_IMAGE_WIDTH:    width_r    <= cfg_wdata[cro_pkg::DIM_W-1:0];
        cro_pkg::REG_IMAGE_HEIGHT:   height_r   <= cfg_wdata[cro_pkg::DIM_W-1:0];
      endcase
    end
  end

  always_comb begin
    two_r     = $signed(cro_pkg::HI_W'({radius_r, 1'b0}));
    thick_ext = cro_pkg::HI_W'(thick_r);
    hi_nxt    = two_r + thick_ext;
    lo_nxt    = two_r - thick_ext;
    hi_mag    = hi_r[cro_pkg::HI_W-2:0];
    lo_mag    = lo_r[cro_pkg::HI_W-2:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_r     <= cro_pkg::HI_W'(1);
      lo_r     <= -cro_pkg::HI_W'(1);
      filled_r <= 1'b0;
      hi_sq_r  <= cro_pkg::HSQ_W'(1);
      lo_sq_r  <= cro_pkg::HSQ_W'(1);
      r_sq_r   <= '0;
      hi_pos_r <= 1'b1;
      lo_pos_r <= 1'b0;
    end else begin
      hi_r     <= hi_nxt;
      lo_r     <= lo_nxt;
      filled_r <= (thick_r == cro_pkg::THICK_FILLED);
      hi_sq_r  <= cro_pkg::HSQ_W'(hi_mag) * cro_pkg::HSQ_W'(hi_mag);
      lo_sq_r  <= cro_pkg::HSQ_W'(lo_mag) * cro_pkg::HSQ_W'(lo_mag);
      r_sq_r   <= cro_pkg::RSQ_W'(radius_r) * cro_pkg::RSQ_W'(radius_r);
      hi_pos_r <= !hi_r[cro_pkg::HI_W-1] && (hi_r != '0);
      lo_pos_r <= !lo_r[cro_pkg::HI_W-1] && (lo_r != '0);
    end
  end

  always_comb begin
    cfg.center_x = center_x_r;
    cfg.center_y = center_y_r;
    cfg.radius   = radius_r;
    cfg.color    = color_r;
    cfg.mode     = mode_r;
    cfg.width    = width_r;
    cfg.height   = height_r;
    cfg.filled   = filled_r;
    cfg.hi_pos   = hi_pos_r;
    cfg.lo_pos   = lo_pos_r;
    cfg.hi_sq    = hi_sq_r;
    cfg.lo_sq    = lo_sq_r;
    cfg.r_sq     = r_sq_r;
  end

endmodule

`default_nettype wire

// File: rtl/cro_pipe.sv
// ============================================================================
// cro_pipe
// Five-stage pixel pipeline: offset, magnitude, square, sum, test and merge.
// ============================================================================
`default_nettype none

module cro_pipe (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire cro_pkg::in_t  in_data,
  input  wire cro_pkg::cfg_t cfg,
  output logic               out_valid,
  output cro_pkg::out_t      out_data
);

  // stage 1: offsets from center, image bounds
  logic                             v1_r;
  logic signed [cro_pkg::DX_W-1:0]  dx1_r, dx1_nxt;
  logic signed [cro_pkg::DX_W-1:0]  dy1_r, dy1_nxt;
  logic                             in1_r, in1_nxt;
  logic [cro_pkg::PIX_W-1:0]        pix1_r;

  // stage 2: magnitudes, box test
  logic                             v2_r;
  logic [cro_pkg::ABS_W-1:0]        ax2_r, ax2_nxt;
  logic [cro_pkg::ABS_W-1:0]        ay2_r, ay2_nxt;
  logic                             box2_r, box2_nxt;
  logic                             in2_r;
  logic [cro_pkg::PIX_W-1:0]        pix2_r;

  // stage 3: squares
  logic                             v3_r;
  logic [cro_pkg::SQ_W-1:0]         sx3_r;
  logic [cro_pkg::SQ_W-1:0]         sy3_r;
  logic                             box3_r;
  logic                             in3_r;
  logic [cro_pkg::PIX_W-1:0]        pix3_r;

  // stage 4: squared distance
  logic                             v4_r;
  logic [cro_pkg::D_W-1:0]          d4_r;
  logic                             box4_r;
  logic                             in4_r;
  logic [cro_pkg::PIX_W-1:0]        pix4_r;

  // stage 5: shape test and merge
  logic                             v5_r;
  cro_pkg::out_t                    out5_r, out5_nxt;

  logic [cro_pkg::CMP_W-1:0]        d4x4;
  logic [cro_pkg::CMP_W-1:0]        d_ext;
  logic                             ring_hit;
  logic                             fill_hit;
  logic                             hit;
  logic [cro_pkg::PIX_W-1:0]        mask;

  always_comb begin
    dx1_nxt = $signed(cro_pkg::DX_W'(in_data.pixel_x)) - cro_pkg::DX_W'(cfg.center_x);
    dy1_nxt = $signed(cro_pkg::DX_W'(in_data.pixel_y)) - cro_pkg::DX_W'(cfg.center_y);
    in1_nxt = (cro_pkg::DIM_W'(in_data.pixel_x) < cfg.width) &&
              (cro_pkg::DIM_W'(in_data.pixel_y) < cfg.height);
  end

  always_comb begin
    ax2_nxt  = dx1_r[cro_pkg::DX_W-1] ? cro_pkg::ABS_W'(-dx1_r) : cro_pkg::ABS_W'(dx1_r);
    ay2_nxt  = dy1_r[cro_pkg::DX_W-1] ? cro_pkg::ABS_W'(-dy1_r) : cro_pkg::ABS_W'(dy1_r);
    box2_nxt = (cro_pkg::BOX_W'(ax2_nxt) < cro_pkg::BOX_W'(cfg.radius)) &&
               (cro_pkg::BOX_W'(ay2_nxt) < cro_pkg::BOX_W'(cfg.radius));
  end

  always_comb begin
    d4x4     = cro_pkg::CMP_W'({d4_r, 2'b00});
    d_ext    = cro_pkg::CMP_W'(d4_r);
    ring_hit = cfg.hi_pos && (d4x4 < cro_pkg::CMP_W'(cfg.hi_sq)) &&
               (!cfg.lo_pos || (cro_pkg::CMP_W'(cfg.lo_sq) <= d4x4));
    fill_hit = box4_r && (d_ext <= cro_pkg::CMP_W'(cfg.r_sq));
    hit      = in4_r && (cfg.filled ? fill_hit : ring_hit);
    mask     = cro_pkg::chan_mask(cfg.mode);
    out5_nxt.pixel_out = hit ? ((pix4_r & ~mask) | (cfg.color & mask)) : pix4_r;
    out5_nxt.painted   = hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    dx1_r  <= dx1_nxt;
    dy1_r  <= dy1_nxt;
    in1_r  <= in1_nxt;
    pix1_r <= in_data.pixel_in;

    ax2_r  <= ax2_nxt;
    ay2_r  <= ay2_nxt;
    box2_r <= box2_nxt;
    in2_r  <= in1_r;
    pix2_r <= pix1_r;

    sx3_r  <= cro_pkg::SQ_W'(ax2_r) * cro_pkg::SQ_W'(ax2_r);
    sy3_r  <= cro_pkg::SQ_W'(ay2_r) * cro_pkg::SQ_W'(ay2_r);
    box3_r <= box2_r;
    in3_r  <= in2_r;
    pix3_r <= pix2_r;

    d4_r   <= cro_pkg::D_W'(sx3_r) + cro_pkg::D_W'(sy3_r);
    box4_r <= box3_r;
    in4_r  <= in3_r;
    pix4_r <= pix3_r;

    out5_r <= out5_nxt;
  end

  assign out_valid = v5_r;
  assign out_data  = out5_r;

endmodule

`default_nettype wire

// File: rtl/circle_ring_overlay.sv
// ============================================================================
// circle_ring_overlay
// Per-pixel overlay of a filled disc or ring onto a pixel stream.
//
//   channel   ports                          handshake
//   input     start, busy, in_data           taken when start && !busy
//   result    out_valid, out_data            one-cycle strobe, no back-pressure
//   config    cfg_we, cfg_index, cfg_wdata   written when cfg_we
//
// One pixel per cycle; busy is always low. A result leaves the five-stage test
// pipeline (offset, magnitude, square, sum, compare) after its pixel is taken.
// Derived shape constants (ring bounds, then their squares) are registered
// behind the config registers. Synchronous reset clears the pipeline valids
// and loads the register defaults. The receiver cannot stall; nothing is ever held.
// ============================================================================
`default_nettype none

module circle_ring_overlay (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire cro_pkg::in_t                  in_data,
  output logic                               out_valid,
  output cro_pkg::out_t                      out_data,
  input  wire logic                          cfg_we,
  input  wire logic [cro_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cro_pkg::CFG_DAT_W-1:0] cfg_wdata
);

  cro_pkg::cfg_t cfg;
  logic          in_valid;

  assign busy     = 1'b0;
  assign in_valid = start && !busy;

  cro_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cro_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
